@@ src/gsbf_pkg.sv @@
package gsbf_pkg;

  localparam logic [15:0] BLOCK_MAX = 16'd65535;
  localparam logic [31:0] CRC_POLY  = 32'hedb88320;
  localparam logic [31:0] CRC_INIT  = 32'hffffffff;

  localparam logic [0:0] FUNC_START = 1'b0;
  localparam logic [0:0] FUNC_DATA  = 1'b1;

  // byte positions within one run of results
  localparam logic [4:0] P_GZ0      = 5'd0;
  localparam logic [4:0] P_GZ_LAST  = 5'd9;
  localparam logic [4:0] P_BLK0     = 5'd10;
  localparam logic [4:0] P_BLK_LAST = 5'd14;
  localparam logic [4:0] P_DATA     = 5'd15;
  localparam logic [4:0] P_TRL0     = 5'd16;
  localparam logic [4:0] P_TRL_LAST = 5'd23;

  typedef struct packed {
    logic        has_gz;
    logic        has_blk;
    logic        has_data;
    logic        has_trl;
    logic        rej;
    logic        blk_final;
    logic [15:0] blk_len;
    logic [7:0]  data;
    logic [31:0] trl_crc;
    logic [31:0] trl_len;
  } run_t;

  function automatic logic [7:0] gz_head(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h1f;
      4'd1:    b = 8'h8b;
      4'd2:    b = 8'h08;
      4'd9:    b = 8'hff;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int j = 0; j < 8; j++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

@@ src/gzip_stored_block_framer.sv @@
// gzip_stored_block_framer
// Input beats: tuser = func (0 start frame, 1 data byte), tdata = payload byte.
// Output beats: one gzip stream byte each; tlast marks the final byte caused
// by an input beat, tuser[0] marks the last trailer byte of the frame and
// tuser[1] marks a data byte rejected because no frame was open.
// Write total_length through cfg_we/cfg_wdata before a start beat; it is
// sampled at the start.
// Each input beat is latched into a run register; an emitter walks it one
// output byte per cycle when not stalled: 10 header bytes for a start (23
// for an empty frame), 1 byte for plain data, 6 with a block header before
// it, plus 8 trailer bytes after the frame's last byte. The next beat is
// taken in the cycle the current run emits its last byte, so unstalled data
// streams at one byte per cycle. Output passes run, then output register.
// A stalled out_tready holds the output register and the emitter; input is
// back-pressured once the run register is full.
// Reset clears control state and presets the CRC; no frame is open after it.
module gzip_stored_block_framer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  output logic [1:0] out_tuser   // [0] frame_done, [1] rejected
);

  logic [31:0] total_length_r;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] left_frame_r, left_frame_nxt;
  logic [15:0] left_blk_r, left_blk_nxt;
  logic        open_r, open_nxt;
  logic [31:0] frame_len_r, frame_len_nxt;

  gsbf_pkg::run_t run_r, run_nxt;
  logic        run_active_r, run_active_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [4:0]  last_pos, next_pos, start_pos;

  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_done_r, out_rej_r;
  logic        out_valid_r, out_valid_nxt;

  logic emit_en, run_done, in_fire;
  logic [15:0] chunk, blk_base, blk_dec;
  logic [31:0] left_dec, crc_upd;

  assign emit_en   = run_active_r && (!out_valid_r || out_tready);
  assign run_done  = emit_en && (pos_r == last_pos);
  assign in_tready = !run_active_r || run_done;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    if (run_r.has_trl)       last_pos = gsbf_pkg::P_TRL_LAST;
    else if (run_r.has_data) last_pos = gsbf_pkg::P_DATA;
    else if (run_r.has_blk)  last_pos = gsbf_pkg::P_BLK_LAST;
    else                     last_pos = gsbf_pkg::P_GZ_LAST;
  end

  always_comb begin
    if (pos_r == gsbf_pkg::P_GZ_LAST) begin
      next_pos = run_r.has_blk ? gsbf_pkg::P_BLK0 :
                 (run_r.has_data ? gsbf_pkg::P_DATA : gsbf_pkg::P_TRL0);
    end else if (pos_r == gsbf_pkg::P_BLK_LAST) begin
      next_pos = run_r.has_data ? gsbf_pkg::P_DATA : gsbf_pkg::P_TRL0;
    end else begin
      next_pos = pos_r + 5'd1;
    end
  end

  always_comb begin
    if (run_nxt.has_gz)       start_pos = gsbf_pkg::P_GZ0;
    else if (run_nxt.has_blk) start_pos = gsbf_pkg::P_BLK0;
    else                      start_pos = gsbf_pkg::P_DATA;
  end

  assign chunk    = (left_frame_r > {16'd0, gsbf_pkg::BLOCK_MAX}) ? gsbf_pkg::BLOCK_MAX
                                                                   : left_frame_r[15:0];
  assign blk_base = (left_blk_r == 16'd0) ? chunk : left_blk_r;
  assign blk_dec  = blk_base - 16'd1;
  assign left_dec = left_frame_r - 32'd1;
  assign crc_upd  = gsbf_pkg::crc32_byte(crc_r, in_tdata);

  always_comb begin
    crc_nxt        = crc_r;
    left_frame_nxt = left_frame_r;
    left_blk_nxt   = left_blk_r;
    open_nxt       = open_r;
    frame_len_nxt  = frame_len_r;
    run_nxt        = run_r;
    if (in_fire) begin
      run_nxt = '0;
      if (in_tuser == gsbf_pkg::FUNC_START) begin
        crc_nxt          = gsbf_pkg::CRC_INIT;
        frame_len_nxt    = total_length_r;
        left_frame_nxt   = total_length_r;
        left_blk_nxt     = 16'd0;
        open_nxt         = (total_length_r != 32'd0);
        run_nxt.has_gz   = 1'b1;
        run_nxt.has_blk  = (total_length_r == 32'd0);
        run_nxt.has_trl  = (total_length_r == 32'd0);
        run_nxt.blk_final = 1'b1;
        run_nxt.blk_len  = 16'd0;
        run_nxt.trl_crc  = 32'd0;
        run_nxt.trl_len  = 32'd0;
      end else if (!open_r) begin
        run_nxt.has_data = 1'b1;
        run_nxt.rej      = 1'b1;
        run_nxt.data     = 8'd0;
      end else begin
        run_nxt.has_data  = 1'b1;
        run_nxt.data      = in_tdata;
        run_nxt.has_blk   = (left_blk_r == 16'd0);
        run_nxt.blk_len   = chunk;
        run_nxt.blk_final = ({16'd0, chunk} == left_frame_r);
        crc_nxt           = crc_upd;
        left_frame_nxt    = left_dec;
        left_blk_nxt      = blk_dec;
        run_nxt.trl_crc   = ~crc_upd;
        run_nxt.trl_len   = frame_len_r;
        if (left_dec == 32'd0) begin
          run_nxt.has_trl = 1'b1;
          open_nxt        = 1'b0;
          left_blk_nxt    = 16'd0;
        end
      end
    end
  end

  always_comb begin
    case (pos_r) inside
      [gsbf_pkg::P_GZ0:gsbf_pkg::P_GZ_LAST]: out_byte_nxt = gsbf_pkg::gz_head(pos_r[3:0]);
      5'd10:            out_byte_nxt = {7'd0, run_r.blk_final};
      5'd11:            out_byte_nxt = run_r.blk_len[7:0];
      5'd12:            out_byte_nxt = run_r.blk_len[15:8];
      5'd13:            out_byte_nxt = ~run_r.blk_len[7:0];
      5'd14:            out_byte_nxt = ~run_r.blk_len[15:8];
      5'd15:            out_byte_nxt = run_r.data;
      5'd16:            out_byte_nxt = run_r.trl_crc[7:0];
      5'd17:            out_byte_nxt = run_r.trl_crc[15:8];
      5'd18:            out_byte_nxt = run_r.trl_crc[23:16];
      5'd19:            out_byte_nxt = run_r.trl_crc[31:24];
      5'd20:            out_byte_nxt = run_r.trl_len[7:0];
      5'd21:            out_byte_nxt = run_r.trl_len[15:8];
      5'd22:            out_byte_nxt = run_r.trl_len[23:16];
      5'd23:            out_byte_nxt = run_r.trl_len[31:24];
      default:          out_byte_nxt = 8'd0;
    endcase
  end

  assign run_active_nxt = in_fire ? 1'b1 : (run_done ? 1'b0 : run_active_r);
  assign pos_nxt        = in_fire ? start_pos : (emit_en ? next_pos : pos_r);
  assign out_valid_nxt  = emit_en ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_length_r <= 32'd0;
      crc_r          <= gsbf_pkg::CRC_INIT;
      left_frame_r   <= 32'd0;
      left_blk_r     <= 16'd0;
      open_r         <= 1'b0;
      frame_len_r    <= 32'd0;
      run_active_r   <= 1'b0;
      pos_r          <= gsbf_pkg::P_GZ0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) total_length_r <= cfg_wdata;
      crc_r        <= crc_nxt;
      left_frame_r <= left_frame_nxt;
      left_blk_r   <= left_blk_nxt;
      open_r       <= open_nxt;
      frame_len_r  <= frame_len_nxt;
      run_active_r <= run_active_nxt;
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    if (emit_en) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= (pos_r == last_pos);
      out_done_r <= (pos_r == gsbf_pkg::P_TRL_LAST);
      out_rej_r  <= run_r.rej && (pos_r == gsbf_pkg::P_DATA);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_rej_r, out_done_r};

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame_done without last_of_run");

  a_rej_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && out_tdata == 8'd0 && !out_tuser[0])
    else $error("rejected beat malformed");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_active_r |-> pos_r <= last_pos)
    else $error("emitter ran past end of run");

  a_open_left: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> left_frame_r != 32'd0)
    else $error("open frame with no bytes left");

endmodule

@@ tb/sv/tb_gzip_stored_block_framer.sv @@
module tb_gzip_stored_block_framer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RAND_ITEMS  = 300;
  localparam int DRAIN_WAIT  = 8;
  localparam logic [79:0] GZIP_MAGIC = 80'h1f8b08000000000000ff;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       done;
    logic       rej;
  } gz_beat_t;

  typedef enum int {ROW_CFG, ROW_ITEM, ROW_REJ} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        func;
    logic [7:0]  data;
    logic [31:0] len;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  gzip_stored_block_framer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // framer shadow state
  logic [31:0] len_reg;
  logic [31:0] crc_run;
  logic [31:0] frame_left;
  logic [15:0] block_left;
  logic        frame_is_open;
  logic [31:0] frame_len;

  logic [7:0]  seq_byte [0:31];
  logic        seq_done [0:31];
  logic        seq_rej  [0:31];
  int          seq_n;

  gz_beat_t    pending_bytes [$];
  int          mismatches;
  int          cycle_cnt;
  bit          quiet;
  int          ready_hold;

  dir_row_t dir_plan [0:23] = '{
    '{ROW_REJ,  gsbf_pkg::FUNC_DATA,  8'h00, 32'd0},
    '{ROW_REJ,  gsbf_pkg::FUNC_DATA,  8'hff, 32'd0},
    '{ROW_CFG,  gsbf_pkg::FUNC_START, 8'h00, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_START, 8'hff, 32'd0},
    '{ROW_REJ,  gsbf_pkg::FUNC_DATA,  8'ha5, 32'd0},
    '{ROW_CFG,  gsbf_pkg::FUNC_START, 8'h00, 32'd1},
    '{ROW_ITEM, gsbf_pkg::FUNC_START, 8'h00, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_DATA,  8'hff, 32'd0},
    '{ROW_CFG,  gsbf_pkg::FUNC_START, 8'h00, 32'd3},
    '{ROW_ITEM, gsbf_pkg::FUNC_START, 8'h00, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_DATA,  8'h00, 32'd0},
    '{ROW_CFG,  gsbf_pkg::FUNC_START, 8'h00, 32'hffff_ffff},
    '{ROW_ITEM, gsbf_pkg::FUNC_DATA,  8'h80, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_DATA,  8'h7f, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_START, 8'h00, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_DATA,  8'h01, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_DATA,  8'hfe, 32'd0},
    '{ROW_CFG,  gsbf_pkg::FUNC_START, 8'h00, 32'd2},
    '{ROW_ITEM, gsbf_pkg::FUNC_START, 8'h00, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_DATA,  8'h55, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_START, 8'h00, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_DATA,  8'haa, 32'd0},
    '{ROW_ITEM, gsbf_pkg::FUNC_DATA,  8'h33, 32'd0},
    '{ROW_REJ,  gsbf_pkg::FUNC_DATA,  8'h11, 32'd0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    int          k;
    r = c;
    for (k = 0; k < 8; k++) begin
      r = {1'b0, r[31:1]} ^ ({32{r[0] ^ b[k]}} & gsbf_pkg::CRC_POLY);
    end
    return r;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic done, input logic rej);
    seq_byte[seq_n] = b;
    seq_done[seq_n] = done;
    seq_rej[seq_n]  = rej;
    seq_n++;
  endtask

  task automatic add_block_hdr(input logic [15:0] len, input logic is_final);
    add_byte({7'd0, is_final}, 1'b0, 1'b0);
    add_byte(len[7:0], 1'b0, 1'b0);
    add_byte(len[15:8], 1'b0, 1'b0);
    add_byte(~len[7:0], 1'b0, 1'b0);
    add_byte(~len[15:8], 1'b0, 1'b0);
  endtask

  task automatic add_trailer();
    logic [31:0] crc_out;
    int          k;
    crc_out = ~crc_run;
    for (k = 0; k < 4; k++) add_byte(crc_out[8*k +: 8], 1'b0, 1'b0);
    for (k = 0; k < 4; k++) add_byte(frame_len[8*k +: 8], k == 3, 1'b0);
  endtask

  // expected gzip bytes for one accepted beat
  task automatic compute_gzip_bytes(input logic f, input logic [7:0] d);
    logic [15:0] chunk;
    int          k;
    seq_n = 0;
    if (f == gsbf_pkg::FUNC_START) begin
      for (k = 0; k < 10; k++) add_byte(GZIP_MAGIC[79 - 8*k -: 8], 1'b0, 1'b0);
      crc_run    = gsbf_pkg::CRC_INIT;
      frame_len  = len_reg;
      frame_left = len_reg;
      block_left = '0;
      if (len_reg == 0) begin
        add_block_hdr(16'd0, 1'b1);
        add_trailer();
        frame_is_open = 1'b0;
      end else begin
        frame_is_open = 1'b1;
      end
    end else if (!frame_is_open) begin
      add_byte(8'h00, 1'b0, 1'b1);
    end else begin
      if (block_left == 0) begin
        chunk = (frame_left > {16'd0, gsbf_pkg::BLOCK_MAX}) ? gsbf_pkg::BLOCK_MAX
                                                            : frame_left[15:0];
        add_block_hdr(chunk, {16'd0, chunk} == frame_left);
        block_left = chunk;
      end
      add_byte(d, 1'b0, 1'b0);
      crc_run    = crc_next(crc_run, d);
      block_left = block_left - 16'd1;
      frame_left = frame_left - 32'd1;
      if (frame_left == 0) begin
        add_trailer();
        frame_is_open = 1'b0;
        block_left    = '0;
      end
    end
    for (k = 0; k < seq_n; k++)
      pending_bytes.push_back('{seq_byte[k], k == seq_n - 1, seq_done[k], seq_rej[k]});
  endtask

  // leaves in_tvalid high; caller pushes again or calls wait_idle in the same step
  task automatic push_item(input logic f, input logic [7:0] d, input bit rej_typed);
    int gap;
    gap = quiet ? 0 : pick_pause();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (rej_typed) pending_bytes.push_back('{8'h00, 1'b1, 1'b0, 1'b1});
    else compute_gzip_bytes(f, d);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_len(input logic [31:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_reg = v;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40) $display("ERROR %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else if (out_tready) begin
      ready_hold = pick_pause();
      if (ready_hold != 0) begin
        out_tready <= 1'b0;
        ready_hold--;
      end else begin
        ready_hold = $urandom_range(0, 6);
      end
    end else begin
      out_tready <= 1'b1;
      ready_hold = $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    gz_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 0);
      end else begin
        want = pending_bytes.pop_front();
        if (out_tdata !== want.b) report_mismatch("out_byte", out_tdata, want.b);
        if (out_tlast !== want.last) report_mismatch("last_of_run", out_tlast, want.last);
        if (out_tuser[0] !== want.done) report_mismatch("frame_done", out_tuser[0], want.done);
        if (out_tuser[1] !== want.rej) report_mismatch("rejected", out_tuser[1], want.rej);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout, %0d beats outstanding", pending_bytes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int          i;
    int          n;
    int          r;
    int          rand_items;
    logic [31:0] len;
    mismatches    = 0;
    cycle_cnt     = 0;
    quiet         = 1'b0;
    ready_hold    = 0;
    len_reg       = '0;
    crc_run       = gsbf_pkg::CRC_INIT;
    frame_left    = '0;
    block_left    = '0;
    frame_is_open = 1'b0;
    frame_len     = '0;
    rand_items    = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_plan[i]) begin
      case (dir_plan[i].kind)
        ROW_CFG:  write_len(dir_plan[i].len);
        ROW_ITEM: push_item(dir_plan[i].func, dir_plan[i].data, 1'b0);
        default:  push_item(dir_plan[i].func, dir_plan[i].data, 1'b1);
      endcase
    end

    while (rand_items < RAND_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) len = 32'd0;
      else if (r < 75) len = $urandom_range(1, 20);
      else if (r < 85) len = $urandom_range(21, 40);
      else if (r < 93) len = $urandom;
      else len = 32'hffff_ffff;
      write_len(len);
      // stray data: continues an open frame or gets rejected
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      for (i = 0; i < n; i++) push_item(gsbf_pkg::FUNC_DATA, 8'($urandom), 1'b0);
      rand_items += n;
      push_item(gsbf_pkg::FUNC_START, 8'($urandom), 1'b0);
      if (len <= 40 && $urandom_range(0, 3) != 0) n = len;
      else n = $urandom_range(0, 12);
      for (i = 0; i < n; i++) push_item(gsbf_pkg::FUNC_DATA, 8'($urandom), 1'b0);
      rand_items += n + 1;
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) push_item(1'($urandom), 8'($urandom), 1'b0);
      rand_items += n;
    end

    quiet = 1'b0;
    wait_idle();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
